// File: rtl/cle_pkg.sv
// Shared types and key codes for the cursor line editor.
// No dependencies.
package cle_pkg;

	typedef logic [7:0] char_t;

	localparam char_t KEY_DELETE = 8'h2D;
	localparam char_t KEY_LEFT   = 8'h3C;
	localparam char_t KEY_RIGHT  = 8'h3E;

	function automatic logic is_alnum(input char_t c);
		return (c >= 8'h30 && c <= 8'h39) ||
			(c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

// File: rtl/cle_stack.sv
// Character store for one side of the cursor: one write port and one
// read port with registered read data. Depends on cle_pkg.
module cle_stack #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  cle_pkg::char_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output cle_pkg::char_t  rdata
);
	import cle_pkg::*;

	char_t mem [DEPTH];
	char_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/cursor_line_editor.sv
// Cursor line editor: two character stacks meeting at the cursor.
// Depends on cle_pkg and cle_stack.
//
// Input channel (in_valid / in_stall) takes one key item with a line_done
// flag. Letters and digits insert at the cursor, '-' deletes left of it,
// '<' and '>' move it; other bytes are ignored. An insert while the line
// holds CAPACITY characters is dropped and sets the sticky overflow flag.
// Inserts, deletes and ignored keys complete as they are taken; a cursor
// move reads one stack memory, then writes into the other in S_MOVE.
// A line_done item emits the line on the output channel (out_valid /
// out_stall), one character per item, left to right, last set on the
// final one; an empty line gives a single item with char_valid low.
// The first character item passes from S_FLUSH through the stack read
// stage to the output register; an empty line's item enters the read
// stage as line_done is taken. While the output does not stall the flush
// reads one stored character, and a line streams out one item, per cycle.
// A stall on the output holds the output register and pauses the flush;
// input is accepted while a finished item waits in the output register.
// Reset clears the counts, the overflow flag and all handshake state; the
// stack memories are not cleared and need no clearing pass.
module cursor_line_editor #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cle_pkg::char_t  key,
	input  logic            line_done,
	output logic            out_valid,
	input  logic            out_stall,
	output cle_pkg::char_t  text_char,
	output logic            char_valid,
	output logic            last,
	output logic            overflow
);
	import cle_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {S_IDLE, S_MOVE, S_FLUSH, S_DRAIN} state_t;

	state_t        state_q;
	logic [CW-1:0] lc_q, rc_q, idx_q, total_q;
	logic          ovf_q;
	logic          dir_q;
	logic          v_s1, sel_s1, cval_s1, last_s1;
	logic          out_valid_q, char_valid_q, last_q, overflow_q;
	char_t         text_char_q;

	logic          l_we, l_re, r_we, r_re;
	logic [AW-1:0] l_waddr, l_raddr, r_waddr, r_raddr;
	char_t         l_wdata, r_wdata, l_rdata, r_rdata;

	logic          accept, out_load, fl_issue, fl_last, fl_left, v_set;
	logic [CW:0]   sum_w;
	logic [CW-1:0] idx_next, r_idx, lc_dec, rc_dec;
	char_t         s1_char;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign sum_w    = {1'b0, lc_q} + {1'b0, rc_q};
	assign out_load = v_s1 && (!out_valid_q || !out_stall);
	assign fl_issue = (state_q == S_FLUSH) && (!v_s1 || out_load);
	assign v_set    = fl_issue || (accept && line_done && (sum_w == '0));
	assign idx_next = CW'(idx_q + CW'(1));
	assign fl_last  = (idx_next == total_q);
	assign fl_left  = (idx_q < lc_q);
	assign r_idx    = CW'(total_q - idx_next);
	assign lc_dec   = CW'(lc_q - CW'(1));
	assign rc_dec   = CW'(rc_q - CW'(1));
	assign s1_char  = !cval_s1 ? '0 : (sel_s1 ? r_rdata : l_rdata);

	always_comb begin
		l_we    = 1'b0;
		l_waddr = lc_q[AW-1:0];
		l_wdata = key;
		l_re    = 1'b0;
		l_raddr = lc_dec[AW-1:0];
		r_we    = 1'b0;
		r_waddr = rc_q[AW-1:0];
		r_wdata = l_rdata;
		r_re    = 1'b0;
		r_raddr = rc_dec[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept && !line_done) begin
					priority if (is_alnum(key)) begin
						l_we = (sum_w < (CW+1)'(CAPACITY));
					end else if (key == KEY_LEFT) begin
						l_re = (lc_q != '0);
					end else if (key == KEY_RIGHT) begin
						r_re = (rc_q != '0);
					end else begin
					end
				end
			end
			S_MOVE: begin
				if (dir_q) begin
					l_we    = 1'b1;
					l_wdata = r_rdata;
				end else begin
					r_we = 1'b1;
				end
			end
			S_FLUSH: begin
				if (fl_issue) begin
					l_re    = fl_left;
					r_re    = !fl_left;
					l_raddr = idx_q[AW-1:0];
					r_raddr = r_idx[AW-1:0];
				end
			end
			S_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	cle_stack #(.DEPTH(CAPACITY), .AW(AW)) u_left (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	cle_stack #(.DEPTH(CAPACITY), .AW(AW)) u_right (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lc_q        <= '0;
			rc_q        <= '0;
			idx_q       <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			dir_q       <= 1'b0;
			v_s1        <= 1'b0;
			sel_s1      <= 1'b0;
			cval_s1     <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			text_char_q <= '0;
			char_valid_q <= 1'b0;
			last_q      <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				text_char_q  <= s1_char;
				char_valid_q <= cval_s1;
				last_q       <= last_s1;
				overflow_q   <= ovf_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= v_set || (v_s1 && !out_load);

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (line_done) begin
							idx_q   <= '0;
							total_q <= sum_w[CW-1:0];
							if (sum_w == '0) begin
								cval_s1 <= 1'b0;
								last_s1 <= 1'b1;
								state_q <= S_DRAIN;
							end else begin
								state_q <= S_FLUSH;
							end
						end else begin
							priority if (is_alnum(key)) begin
								if (sum_w < (CW+1)'(CAPACITY)) begin
									lc_q <= CW'(lc_q + CW'(1));
								end else begin
									ovf_q <= 1'b1;
								end
							end else if (key == KEY_DELETE) begin
								if (lc_q != '0) begin
									lc_q <= CW'(lc_q - CW'(1));
								end
							end else if (key == KEY_LEFT) begin
								if (lc_q != '0) begin
									lc_q    <= CW'(lc_q - CW'(1));
									dir_q   <= 1'b0;
									state_q <= S_MOVE;
								end
							end else if (key == KEY_RIGHT) begin
								if (rc_q != '0) begin
									rc_q    <= CW'(rc_q - CW'(1));
									dir_q   <= 1'b1;
									state_q <= S_MOVE;
								end
							end else begin
							end
						end
					end
				end
				S_MOVE: begin
					if (dir_q) begin
						lc_q <= CW'(lc_q + CW'(1));
					end else begin
						rc_q <= CW'(rc_q + CW'(1));
					end
					state_q <= S_IDLE;
				end
				S_FLUSH: begin
					if (fl_issue) begin
						sel_s1  <= !fl_left;
						cval_s1 <= 1'b1;
						last_s1 <= fl_last;
						idx_q   <= idx_next;
						if (fl_last) begin
							lc_q    <= '0;
							rc_q    <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (!v_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign text_char  = text_char_q;
	assign char_valid = char_valid_q;
	assign last       = last_q;
	assign overflow   = overflow_q;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		sum_w <= (CW+1)'(CAPACITY))
		else $error("line length above capacity");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !v_s1)
		else $error("read stage busy while taking keys");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fl_issue && fl_last |=> lc_q == '0 && rc_q == '0)
		else $error("stacks not cleared after flush");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !char_valid_q |-> last_q)
		else $error("empty line item without last");

endmodule

// File: tb/sv/cursor_line_editor_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cursor_line_editor: table-driven keys, then random edit lines.
// Emitted characters are checked against table results or an in-bench two-stack line model; needs cle_pkg.
module cursor_line_editor_tb;
	import cle_pkg::*;

	localparam int CAP = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int N_STEPS = 25;

	typedef struct packed {
		char_t ch;
		logic  valid;
		logic  last;
		logic  ovf;
	} char_item_t;

	typedef struct packed {
		char_t      k;
		logic       d;
		logic       typed;
		char_item_t res;
	} step_t;

	localparam char_item_t EMPTY_LINE = {8'h00, 1'b0, 1'b1, 1'b0};
	localparam char_item_t NO_RES = '0;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	char_t key = 8'h00;
	logic  line_done = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	char_t text_char;
	logic  char_valid;
	logic  last;
	logic  overflow;

	cursor_line_editor #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key(key),
		.line_done(line_done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.text_char(text_char),
		.char_valid(char_valid),
		.last(last),
		.overflow(overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// line model
	char_t left_chars [CAP];
	char_t right_chars [CAP];
	int n_left = 0;
	int n_right = 0;
	logic ovf_sticky = 1'b0;

	char_item_t pending_chars [$];
	int mismatches = 0;
	int edits = 0;
	int n_results = 0;
	logic src_quiet = 1'b0;
	step_t steps [N_STEPS];

	function automatic logic is_word_char(input char_t c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic void predict_key(input char_t k, input logic d, ref char_item_t res[$]);
		int total;
		total = n_left + n_right;
		res = {};
		if (d) begin
			if (total == 0) begin
				res.push_back({8'h00, 1'b0, 1'b1, ovf_sticky});
			end else begin
				for (int i = 0; i < n_left; i++)
					res.push_back({left_chars[i], 1'b1, res.size() + 1 == total, ovf_sticky});
				for (int i = n_right; i > 0; i--)
					res.push_back({right_chars[i - 1], 1'b1, res.size() + 1 == total,
						ovf_sticky});
			end
			n_left = 0;
			n_right = 0;
		end else if (is_word_char(k)) begin
			if (total >= CAP) begin
				ovf_sticky = 1'b1;
			end else begin
				left_chars[n_left] = k;
				n_left++;
			end
		end else if (k == KEY_DELETE) begin
			if (n_left > 0)
				n_left--;
		end else if (k == KEY_LEFT) begin
			if (n_left > 0) begin
				n_left--;
				right_chars[n_right] = left_chars[n_left];
				n_right++;
			end
		end else if (k == KEY_RIGHT) begin
			if (n_right > 0) begin
				n_right--;
				left_chars[n_left] = right_chars[n_right];
				n_left++;
			end
		end
	endfunction

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic char_t random_word_char();
		int n;
		n = $urandom_range(0, 61);
		if (n < 10)
			return char_t'(8'h30 + n);
		if (n < 36)
			return char_t'(8'h41 + n - 10);
		return char_t'(8'h61 + n - 36);
	endfunction

	function automatic char_t random_edit_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return random_word_char();
		if (r < 67)
			return KEY_DELETE;
		if (r < 80)
			return KEY_LEFT;
		if (r < 92)
			return KEY_RIGHT;
		return char_t'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_item(input char_t k, input logic d, input logic typed = 1'b0,
			input char_item_t fixed = NO_RES);
		char_item_t res [$];
		int gap;
		gap = pick_gap(src_quiet);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		line_done <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edits++;
		predict_key(k, d, res);
		if (typed)
			pending_chars.push_back(fixed);
		else
			foreach (res[i])
				pending_chars.push_back(res[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_line(input logic long_ok);
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(0, 8);
		else if (r < 95 || !long_ok)
			len = $urandom_range(9, 40);
		else
			len = $urandom_range(41, 80);
		src_quiet = ($urandom_range(0, 3) == 0);
		repeat (len)
			send_item(random_edit_key(), 1'b0);
		send_item(char_t'($urandom_range(0, 255)), 1'b1);
		if ($urandom_range(0, 7) == 0)
			wait_drained();
	endtask

	initial begin
		steps[0]  = {8'h00, 1'b1, 1'b1, EMPTY_LINE};
		steps[1]  = {KEY_DELETE, 1'b0, 1'b0, NO_RES};
		steps[2]  = {KEY_LEFT, 1'b0, 1'b0, NO_RES};
		steps[3]  = {KEY_RIGHT, 1'b0, 1'b0, NO_RES};
		steps[4]  = {8'hFF, 1'b1, 1'b1, EMPTY_LINE};
		steps[5]  = {8'h30, 1'b0, 1'b0, NO_RES};
		steps[6]  = {8'h41, 1'b1, 1'b1, {8'h30, 1'b1, 1'b1, 1'b0}};
		steps[7]  = {8'h7A, 1'b0, 1'b0, NO_RES};
		steps[8]  = {8'h39, 1'b0, 1'b0, NO_RES};
		steps[9]  = {8'h41, 1'b0, 1'b0, NO_RES};
		steps[10] = {8'h5A, 1'b0, 1'b0, NO_RES};
		steps[11] = {8'h61, 1'b0, 1'b0, NO_RES};
		steps[12] = {KEY_LEFT, 1'b0, 1'b0, NO_RES};
		steps[13] = {KEY_LEFT, 1'b0, 1'b0, NO_RES};
		steps[14] = {KEY_DELETE, 1'b0, 1'b0, NO_RES};
		steps[15] = {KEY_RIGHT, 1'b0, 1'b0, NO_RES};
		steps[16] = {KEY_RIGHT, 1'b0, 1'b0, NO_RES};
		steps[17] = {KEY_RIGHT, 1'b0, 1'b0, NO_RES};
		steps[18] = {8'h2F, 1'b0, 1'b0, NO_RES};
		steps[19] = {8'h3A, 1'b0, 1'b0, NO_RES};
		steps[20] = {8'h40, 1'b0, 1'b0, NO_RES};
		steps[21] = {8'h7B, 1'b0, 1'b0, NO_RES};
		steps[22] = {8'h80, 1'b0, 1'b0, NO_RES};
		steps[23] = {8'h00, 1'b0, 1'b0, NO_RES};
		steps[24] = {8'h00, 1'b1, 1'b0, NO_RES};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i])
			send_item(steps[i].k, steps[i].d, steps[i].typed, steps[i].res);

		while (edits < 200)
			run_random_line(1'b0);

		// full buffer: fill, drop inserts, then free one slot from the left side
		wait_drained();
		src_quiet = 1'b0;
		repeat (CAP + 3)
			send_item(random_word_char(), 1'b0);
		repeat (5)
			send_item(KEY_LEFT, 1'b0);
		send_item(KEY_DELETE, 1'b0);
		send_item(random_word_char(), 1'b0);
		send_item(random_word_char(), 1'b0);
		send_item(char_t'($urandom_range(0, 255)), 1'b1);

		while (edits < 450)
			run_random_line(1'b1);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver back-pressure
	int stall_left = 0;
	int sink_run = 0;
	logic sink_quiet = 1'b0;

	always @(posedge clk) begin
		if (sink_run == 0) begin
			sink_quiet = ($urandom_range(0, 3) == 0);
			sink_run = $urandom_range(50, 200);
		end else begin
			sink_run--;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(sink_quiet);
		end
	end

	always @(posedge clk) begin
		char_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unrequested item char %h valid %b last %b ovf %b",
					text_char, char_valid, last, overflow));
			end else begin
				want = pending_chars.pop_front();
				if (text_char !== want.ch || char_valid !== want.valid ||
						last !== want.last || overflow !== want.ovf)
					report_mismatch($sformatf(
						"item %0d: got %h/%b/%b/%b want %h/%b/%b/%b (char/valid/last/ovf)",
						n_results, text_char, char_valid, last, overflow,
						want.ch, want.valid, want.last, want.ovf));
			end
			n_results++;
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule

// File: files.f
rtl/cle_pkg.sv
rtl/cle_stack.sv
rtl/cursor_line_editor.sv
tb/sv/cursor_line_editor_tb.sv
